/* src/gcb_pkg.sv */
package gcb_pkg;

  // Default sizing
  localparam int GCB_ANGLE_BITS        = 32;
  localparam int GCB_HEADING_FRAC_BITS = 16;
  localparam int GCB_CORDIC_STAGES     = 28;

  // Input field formats
  localparam int GCB_IN_FRAC = 29;
  localparam int GCB_LAT_W   = 31;
  localparam int GCB_LON_W   = 32;

  // Pi with 61 fraction bits
  localparam logic [63:0] GCB_PI_Q61 = 64'h6487ED5110B4611A;

  // Heading constants in whole degrees
  localparam int GCB_DEG_EAST  = 90;
  localparam int GCB_DEG_SOUTH = 180;
  localparam int GCB_DEG_WEST  = 270;
  localparam int GCB_DEG_FULL  = 360;

  // Sideband carried along the rotation chain
  typedef struct packed {
    logic flip;
    logic zero;
  } gcb_rot_tag_t;

  // Restoring division, used only on constants
  function automatic logic [127:0] gcb_udiv(input logic [127:0] num, input logic [127:0] den);
    logic [127:0] rem;
    logic [127:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 127; b >= 0; b--) begin
      rem = {rem[126:0], num[b]};
      quo = {quo[126:0], 1'b0};
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Pi rounded to frac bits
  function automatic logic [127:0] gcb_pi(input int frac);
    return ({64'd0, GCB_PI_Q61} + (128'd1 << (60 - frac))) >> (61 - frac);
  endfunction

  // atan(2^-i) with 61 fraction bits by its power series
  function automatic logic [127:0] gcb_atan_q61(input int i);
    logic [127:0] acc;
    logic [127:0] term;
    int e;
    int k;
    acc = '0;
    if (i == 0) return {64'd0, GCB_PI_Q61} >> 2;
    for (k = 0; k < 64; k++) begin
      e = 61 - i * (2 * k + 1);
      if (e < 0) break;
      term = gcb_udiv(128'd1 << e, 128'(2 * k + 1));
      if (k[0]) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  // atan(2^-i) rounded to frac bits
  function automatic logic [127:0] gcb_atan(input int i, input int frac);
    return (gcb_atan_q61(i) + (128'd1 << (60 - frac))) >> (61 - frac);
  endfunction

  // Inverse CORDIC gain, rounded to frac bits
  function automatic logic [127:0] gcb_gain_inv(input int stages, input int frac);
    longint x;
    longint y;
    longint nx;
    longint ny;
    logic [127:0] num;
    x = 64'sd1 <<< 61;
    y = 0;
    for (int i = 0; i < stages; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
      end
      x = nx;
      y = ny;
    end
    num = (128'd1 << (frac - 3 + 64)) | 128'(64'(x) >> 1);
    return gcb_udiv(num, 128'(64'(x)));
  endfunction

  // floor(((180 << hfrac) << (frac + 3)) / pi), with pi rounded to frac bits
  function automatic logic [127:0] gcb_deg_recip(input int hfrac, input int frac);
    return gcb_udiv((128'(GCB_DEG_SOUTH) << hfrac) << (frac + 3), gcb_pi(frac));
  endfunction

endpackage

/* src/gcb_in_if.sv */
interface gcb_in_if import gcb_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [GCB_LAT_W-1:0] from_lat;
  logic signed [GCB_LON_W-1:0] from_lon;
  logic signed [GCB_LAT_W-1:0] to_lat;
  logic signed [GCB_LON_W-1:0] to_lon;

  modport source(output valid, from_lat, from_lon, to_lat, to_lon, input ready);
  modport sink(input valid, from_lat, from_lon, to_lat, to_lon, output ready);
endinterface

/* src/gcb_out_if.sv */
interface gcb_out_if import gcb_pkg::*; #(
  parameter int HEADING_W = GCB_HEADING_FRAC_BITS + 9
);
  logic                 valid;
  logic                 ready;
  logic [HEADING_W-1:0] heading;
  logic                 undefined_dir;

  modport source(output valid, heading, undefined_dir, input ready);
  modport sink(input valid, heading, undefined_dir, output ready);
endinterface

/* src/gcb_rot_cell.sv */
module gcb_rot_cell import gcb_pkg::*; #(
  parameter int                    AW    = 32,
  parameter int                    IDX   = 0,
  parameter logic signed [AW-1:0]  ATAN  = '0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] x_i,
  input  logic signed [AW-1:0] y_i,
  input  logic signed [AW-1:0] z_i,
  input  gcb_rot_tag_t         tag_i,
  output logic signed [AW-1:0] x_o,
  output logic signed [AW-1:0] y_o,
  output logic signed [AW-1:0] z_o,
  output gcb_rot_tag_t         tag_o
);

  logic signed [AW-1:0] x_r;
  logic signed [AW-1:0] y_r;
  logic signed [AW-1:0] z_r;
  gcb_rot_tag_t         tag_r;

  // Rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (z_i >= 0) begin
        x_r <= x_i - (y_i >>> IDX);
        y_r <= y_i + (x_i >>> IDX);
        z_r <= z_i - ATAN;
      end else begin
        x_r <= x_i + (y_i >>> IDX);
        y_r <= y_i - (x_i >>> IDX);
        z_r <= z_i + ATAN;
      end
      tag_r <= tag_i;
    end
  end

  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign tag_o = tag_r;

endmodule

/* src/gcb_vec_cell.sv */
module gcb_vec_cell import gcb_pkg::*; #(
  parameter int                    XW    = 34,
  parameter int                    IDX   = 0,
  parameter logic signed [XW-1:0]  ATAN  = '0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [XW-1:0] z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [XW-1:0] z_o
);

  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [XW-1:0] z_r;

  // Drive y toward zero and accumulate the angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_i > 0) begin
        x_r <= x_i + (y_i >>> IDX);
        y_r <= y_i - (x_i >>> IDX);
        z_r <= z_i + ATAN;
      end else begin
        x_r <= x_i - (y_i >>> IDX);
        y_r <= y_i + (x_i >>> IDX);
        z_r <= z_i - ATAN;
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

/* src/great_circle_bearing.sv */
// Throughput: one transaction per cycle while the output is not stalled; one chain of CORDIC
// rotation cells for each of the three angles and one of vectoring cells, plus fixed
// stages for products and degrees.
// The whole pipeline holds while a finished result waits at the output register.
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
module great_circle_bearing import gcb_pkg::*; #(
  parameter int ANGLE_BITS        = GCB_ANGLE_BITS,
  parameter int HEADING_FRAC_BITS = GCB_HEADING_FRAC_BITS,
  parameter int CORDIC_STAGES     = GCB_CORDIC_STAGES
) (
  input  logic      clk,
  input  logic      rst_n,
  gcb_in_if.sink    in_bus,
  gcb_out_if.source out_bus
);

  localparam int FRAC = ANGLE_BITS - 3;
  localparam int AW   = ANGLE_BITS;
  localparam int ZW   = AW + 2;
  localparam int VW   = AW + 1;
  localparam int XW   = AW + 2;
  localparam int HW   = HEADING_FRAC_BITS + 9;
  localparam int N    = CORDIC_STAGES;
  localparam int LAT  = 2 * N + 16;
  localparam int SL   = (FRAC >= GCB_IN_FRAC) ? FRAC - GCB_IN_FRAC : 0;
  localparam int SR   = (FRAC < GCB_IN_FRAC) ? GCB_IN_FRAC - FRAC : 1;
  localparam int RW   = HEADING_FRAC_BITS + 9;
  localparam int CW   = HEADING_FRAC_BITS + 8;
  localparam int QW   = HEADING_FRAC_BITS + 9;
  localparam int NW   = AW + QW;

  localparam logic [127:0] PI_W    = gcb_pi(FRAC);
  localparam logic [127:0] KINV_W  = gcb_gain_inv(N, FRAC);
  localparam logic [127:0] RECIP_W = gcb_deg_recip(HEADING_FRAC_BITS, FRAC);

  localparam logic signed [ZW-1:0] PI_Z      = $signed(PI_W[ZW-1:0]);
  localparam logic signed [ZW-1:0] TWO_PI_Z  = PI_Z <<< 1;
  localparam logic signed [ZW-1:0] HALF_PI_Z = PI_Z >>> 1;
  localparam logic signed [XW-1:0] PI_X      = $signed(PI_W[XW-1:0]);
  localparam logic signed [XW-1:0] TWO_PI_X  = PI_X <<< 1;
  localparam logic signed [AW-1:0] KINV      = $signed(KINV_W[AW-1:0]);
  localparam logic signed [AW-1:0] ONE_A     = AW'(1) <<< FRAC;
  localparam logic [AW-1:0]        PI_U      = PI_W[AW-1:0];
  localparam logic [NW-1:0]        PI_N      = NW'(PI_W[AW-1:0]);
  localparam logic [NW-1:0]        HALF_PI_N = NW'(PI_W[AW-1:0] >> 1);
  localparam logic [RW-1:0]        RECIP     = RECIP_W[RW-1:0];
  localparam logic [CW-1:0]        DEG_C     = CW'(GCB_DEG_SOUTH) << HEADING_FRAC_BITS;
  localparam logic [HW-1:0]        H_FULL    = HW'(GCB_DEG_FULL) << HEADING_FRAC_BITS;
  localparam logic [HW-1:0]        H_SOUTH   = HW'(GCB_DEG_SOUTH) << HEADING_FRAC_BITS;
  localparam logic [HW-1:0]        H_EAST    = HW'(GCB_DEG_EAST) << HEADING_FRAC_BITS;
  localparam logic [HW-1:0]        H_WEST    = HW'(GCB_DEG_WEST) << HEADING_FRAC_BITS;

  typedef struct packed {
    logic          use_sp;
    logic          flag;
    logic [HW-1:0] head;
  } spec_t;

  // Input angle to internal fraction, rounding half up when narrowing
  function automatic logic signed [ZW-1:0] to_frac(input logic signed [33:0] v);
    logic signed [63:0] t;
    t = 64'(v);
    if (FRAC >= GCB_IN_FRAC) t = t <<< SL;
    else t = (t + (64'sd1 <<< (SR - 1))) >>> SR;
    return $signed(t[ZW-1:0]);
  endfunction

  // One step of wrapping into [-pi, pi]
  function automatic logic signed [ZW-1:0] wrap_step(input logic signed [ZW-1:0] z);
    if (z > PI_Z) return z - TWO_PI_Z;
    else if (z < -PI_Z) return z + TWO_PI_Z;
    else return z;
  endfunction

  // Product with magnitude rounded half away from zero
  function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic [VW-1:0]   ua;
    logic [VW-1:0]   ub;
    logic [2*VW-1:0] p;
    logic [2*VW-1:0] q;
    ua = a[VW-1] ? VW'(-a) : VW'(a);
    ub = b[VW-1] ? VW'(-b) : VW'(b);
    p  = (2*VW)'(ua) * (2*VW)'(ub);
    q  = (p + ((2*VW)'(1) << (FRAC - 1))) >> FRAC;
    return (a[VW-1] ^ b[VW-1]) ? -$signed(q[VW-1:0]) : $signed(q[VW-1:0]);
  endfunction

  logic en;
  logic [LAT-1:0] vld_r;

  // Whole pipeline advances unless the output holds an untaken result
  assign en           = !vld_r[LAT-1] || out_bus.ready;
  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_bus.valid};
    end
  end

  // Lanes: 0 start latitude, 1 end latitude, 2 longitude difference
  logic signed [ZW-1:0] a_r  [0:2];
  logic signed [ZW-1:0] w1_r [0:2];
  logic signed [ZW-1:0] w2_r [0:2];
  logic signed [AW-1:0] x0_r [0:2];
  logic signed [AW-1:0] z0_r [0:2];
  gcb_rot_tag_t         t0_r [0:2];
  logic signed [33:0]   dl_raw;

  assign dl_raw = $signed({{2{in_bus.to_lon[31]}}, in_bus.to_lon})
                - $signed({{2{in_bus.from_lon[31]}}, in_bus.from_lon});

  // Capture, wrap twice, then fold into [-pi/2, pi/2]
  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= to_frac(34'(in_bus.from_lat));
      a_r[1] <= to_frac(34'(in_bus.to_lat));
      a_r[2] <= to_frac(dl_raw);
      for (int l = 0; l < 3; l++) begin
        w1_r[l] <= wrap_step(a_r[l]);
        w2_r[l] <= wrap_step(w1_r[l]);
        x0_r[l] <= KINV;
        if (w2_r[l] > HALF_PI_Z) begin
          z0_r[l]      <= $signed(AW'(w2_r[l] - PI_Z));
          t0_r[l].flip <= 1'b1;
          t0_r[l].zero <= (w2_r[l] - PI_Z) == 0;
        end else if (w2_r[l] < -HALF_PI_Z) begin
          z0_r[l]      <= $signed(AW'(w2_r[l] + PI_Z));
          t0_r[l].flip <= 1'b1;
          t0_r[l].zero <= (w2_r[l] + PI_Z) == 0;
        end else begin
          z0_r[l]      <= $signed(AW'(w2_r[l]));
          t0_r[l].flip <= 1'b0;
          t0_r[l].zero <= w2_r[l] == 0;
        end
      end
    end
  end

  logic signed [AW-1:0] rx [0:N][0:2];
  logic signed [AW-1:0] ry [0:N][0:2];
  logic signed [AW-1:0] rz [0:N][0:2];
  gcb_rot_tag_t         rt [0:N][0:2];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign rx[0][l] = x0_r[l];
    assign ry[0][l] = '0;
    assign rz[0][l] = z0_r[l];
    assign rt[0][l] = t0_r[l];
    for (genvar i = 0; i < N; i++) begin : g_rot
      localparam logic [127:0] TAB_W = gcb_atan(i, FRAC);
      gcb_rot_cell #(
        .AW   (AW),
        .IDX  (i),
        .ATAN ($signed(TAB_W[AW-1:0]))
      ) u_cell (
        .clk   (clk),
        .en    (en),
        .x_i   (rx[i][l]),
        .y_i   (ry[i][l]),
        .z_i   (rz[i][l]),
        .tag_i (rt[i][l]),
        .x_o   (rx[i+1][l]),
        .y_o   (ry[i+1][l]),
        .z_o   (rz[i+1][l]),
        .tag_o (rt[i+1][l])
      );
    end
  end

  logic signed [VW-1:0] s_r [0:2];
  logic signed [VW-1:0] c_r [0:2];

  // Sine and cosine with zero-angle and fold corrections
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (rt[N][l].zero) begin
          s_r[l] <= '0;
          c_r[l] <= rt[N][l].flip ? -VW'(ONE_A) : VW'(ONE_A);
        end else begin
          s_r[l] <= rt[N][l].flip ? -VW'(ry[N][l]) : VW'(ry[N][l]);
          c_r[l] <= rt[N][l].flip ? -VW'(rx[N][l]) : VW'(rx[N][l]);
        end
      end
    end
  end

  logic signed [VW-1:0] east_r;
  logic signed [VW-1:0] p1_r;
  logic signed [VW-1:0] p2_r;
  logic signed [VW-1:0] cd_r;
  logic signed [VW-1:0] east2_r;
  logic signed [VW-1:0] p1b_r;
  logic signed [VW-1:0] p3_r;
  logic signed [XW-1:0] north_r;
  logic signed [XW-1:0] east3_r;

  // East and north components
  always_ff @(posedge clk) begin
    if (en) begin
      east_r  <= fmul(s_r[2], c_r[1]);
      p1_r    <= fmul(c_r[0], s_r[1]);
      p2_r    <= fmul(s_r[0], c_r[1]);
      cd_r    <= c_r[2];
      east2_r <= east_r;
      p1b_r   <= p1_r;
      p3_r    <= fmul(p2_r, cd_r);
      north_r <= XW'(p1b_r) - XW'(p3_r);
      east3_r <= XW'(east2_r);
    end
  end

  logic signed [XW-1:0] vx0_r;
  logic signed [XW-1:0] vy0_r;
  logic signed [XW-1:0] vz0_r;
  spec_t                spec_r [0:N+6];

  // Classify the special directions and set up vectoring
  always_ff @(posedge clk) begin
    if (en) begin
      spec_r[0].use_sp <= (east3_r == 0) || (north_r == 0);
      spec_r[0].flag   <= (east3_r == 0) && (north_r == 0);
      if (east3_r == 0 && north_r == 0) spec_r[0].head <= '0;
      else if (east3_r == 0) spec_r[0].head <= (north_r > 0) ? '0 : H_SOUTH;
      else spec_r[0].head <= (east3_r > 0) ? H_EAST : H_WEST;
      if (north_r < 0) begin
        vx0_r <= -north_r;
        vy0_r <= -east3_r;
        vz0_r <= (east3_r >= 0) ? PI_X : -PI_X;
      end else begin
        vx0_r <= north_r;
        vy0_r <= east3_r;
        vz0_r <= '0;
      end
      for (int k = 1; k <= N + 6; k++) spec_r[k] <= spec_r[k-1];
    end
  end

  logic signed [XW-1:0] vx [0:N];
  logic signed [XW-1:0] vy [0:N];
  logic signed [XW-1:0] vz [0:N];

  assign vx[0] = vx0_r;
  assign vy[0] = vy0_r;
  assign vz[0] = vz0_r;

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic [127:0] TAB_W = gcb_atan(i, FRAC);
    gcb_vec_cell #(
      .XW   (XW),
      .IDX  (i),
      .ATAN ($signed(TAB_W[XW-1:0]))
    ) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (vx[i]),
      .y_i (vy[i]),
      .z_i (vz[i]),
      .x_o (vx[i+1]),
      .y_o (vy[i+1]),
      .z_o (vz[i+1])
    );
  end

  logic signed [XW-1:0] zw;
  logic [AW-1:0]        zd_r;
  logic [AW+RW-1:0]     pq_r;
  logic [NW-1:0]        n_r;
  logic [NW-1:0]        n3_r;
  logic [QW-1:0]        qe_r;
  logic [NW-1:0]        qp_r;
  logic [NW-1:0]        r4_r;
  logic [QW-1:0]        q4_r;
  logic [NW-1:0]        r5_r;
  logic [QW-1:0]        q5_r;
  logic [QW-1:0]        q6_r;
  logic [HW-1:0]        hsel;
  logic [HW-1:0]        head_r;
  logic                 flag_r;

  // Wrap the angle into [0, 2*pi)
  always_comb begin
    zw = vz[N];
    if (zw < 0) zw = zw + TWO_PI_X;
    if (zw >= TWO_PI_X) zw = zw - TWO_PI_X;
    if (zw < 0) zw = '0;
  end

  // Degrees: reciprocal estimate, then remainder and up to two corrections
  always_ff @(posedge clk) begin
    if (en) begin
      zd_r <= AW'(zw);
      pq_r <= (AW+RW)'(zd_r) * (AW+RW)'(RECIP);
      n_r  <= NW'(zd_r) * NW'(DEG_C) + HALF_PI_N;
      qe_r <= pq_r[AW +: QW];
      qp_r <= NW'(pq_r[AW +: QW]) * NW'(PI_U);
      n3_r <= n_r;
      r4_r <= n3_r - qp_r;
      q4_r <= qe_r;
      if (r4_r >= PI_N) begin
        r5_r <= r4_r - PI_N;
        q5_r <= q4_r + QW'(1);
      end else begin
        r5_r <= r4_r;
        q5_r <= q4_r;
      end
      q6_r <= (r5_r >= PI_N) ? q5_r + QW'(1) : q5_r;
    end
  end

  // Fold a result of a full turn back to zero
  always_comb begin
    hsel = HW'(q6_r);
    if (hsel >= H_FULL) hsel = hsel - H_FULL;
    if (hsel >= H_FULL) hsel = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_r <= spec_r[N+6].use_sp ? spec_r[N+6].head : hsel;
      flag_r <= spec_r[N+6].flag;
    end
  end

  assign out_bus.valid         = vld_r[LAT-1];
  assign out_bus.heading       = head_r;
  assign out_bus.undefined_dir = flag_r;

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.undefined_dir |-> out_bus.heading == '0)
    else $error("undefined direction with nonzero heading");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> out_bus.heading < H_FULL)
    else $error("heading at or above a full turn");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAT-1] && !out_bus.ready |-> !in_bus.ready)
    else $error("input taken while result stalled");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> vld_r[0])
    else $error("accepted transaction lost at pipeline entry");

endmodule
